// File: design/accel_liftoff_detector_assert.svh
// Assertion macros for the liftoff detector.
// Used by the top level only; depends on signals named clk and arst_n in scope.
`ifndef ACCEL_LIFTOFF_DETECTOR_ASSERT_SVH
`define ACCEL_LIFTOFF_DETECTOR_ASSERT_SVH

`ifndef SYNTH
// Checks that an expression holds at every clock edge out of reset.
`define ALD_ASSERT_ALWAYS(label, expr) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (expr)) \
		else $error("liftoff detector check failed");
// Checks that a condition implies another in the same cycle.
`define ALD_ASSERT_IMPLY(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("liftoff detector check failed");
`else
`define ALD_ASSERT_ALWAYS(label, expr)
`define ALD_ASSERT_IMPLY(label, ante, cons)
`endif

`endif

// File: design/aldet_pkg.sv
// Shared types and constants of the liftoff detector.
// Used by the lane, merge, output queue and top level; depends on nothing.
`default_nettype none

package aldet_pkg;

	// Width of one acceleration sample.
	localparam int SAMPLE_BITS = 16;

	// Configuration register widths and reset values.
	localparam int CFG_THR_BITS  = 32;
	localparam int CFG_HOLD_BITS = 8;
	localparam logic [CFG_THR_BITS-1:0]  THR_RESET  = 32'd16777216;
	localparam logic [CFG_HOLD_BITS-1:0] HOLD_RESET = 8'd50;

	// Configuration port: byte address width and register indexes.
	localparam int REG_ADDR_BITS = 3;
	localparam logic REG_THRESH = 1'b0;
	localparam logic REG_HOLD   = 1'b1;

	// Output queue depth and counter widths.
	localparam int OFIFO_DEPTH = 8;
	localparam int OFIFO_AW    = $clog2(OFIFO_DEPTH);
	localparam int OFIFO_CW    = $clog2(OFIFO_DEPTH + 1);

	// One input item.
	typedef struct packed {
		logic signed [SAMPLE_BITS-1:0] accel_x;
		logic signed [SAMPLE_BITS-1:0] accel_y;
		logic signed [SAMPLE_BITS-1:0] accel_z;
		logic                          sample_ok;
	} in_item_t;

	// One result item.
	typedef struct packed {
		logic liftoff;
		logic window_full;
	} out_item_t;

	// Per-item control that travels beside the lane data.
	typedef struct packed {
		logic valid;
		logic ok;
		logic full;
	} ctrl_t;

endpackage

`default_nettype wire

// File: design/aldet_lane.sv
// One axis lane: sample ring, running sum and squared sum magnitude.
// Depends on aldet_pkg.
`default_nettype none

module aldet_lane #(
	parameter int WINDOW = 16,
	localparam int AW    = $clog2(WINDOW),
	localparam int SUM_W = aldet_pkg::SAMPLE_BITS + $clog2(WINDOW),
	localparam int SQ_W  = 2 * SUM_W
) (
	input  wire logic                                     clk,
	input  wire logic                                     arst_n,
	input  wire logic                                     wr_en,
	input  wire logic signed [aldet_pkg::SAMPLE_BITS-1:0] sample,
	input  wire logic [AW-1:0]                            wr_addr,
	input  wire logic [AW-1:0]                            rd_addr,
	input  wire logic                                     old_ok,
	output logic [SQ_W-1:0]                               sq_s2
);
	import aldet_pkg::*;

	logic signed [SAMPLE_BITS-1:0] mem [WINDOW];
	logic signed [SAMPLE_BITS-1:0] rd_q;
	logic signed [SAMPLE_BITS-1:0] old;
	logic signed [SUM_W-1:0]       sum_q;
	logic [SUM_W-1:0]              mag;

	// Ring memory; the read address runs one item ahead so the oldest entry is ready.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= sample;
		end
		rd_q <= mem[rd_addr];
	end

	// Entries not yet written since reset read as zero.
	assign old = old_ok ? rd_q : '0;

	// Running sum over the window.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= '0;
		end else if (wr_en) begin
			sum_q <= sum_q + SUM_W'(sample) - SUM_W'(old);
		end
	end

	// Square of the sum magnitude.
	assign mag = sum_q[SUM_W-1] ? $unsigned(-sum_q) : $unsigned(sum_q);

	always_ff @(posedge clk) begin
		sq_s2 <= SQ_W'(mag) * SQ_W'(mag);
	end

endmodule

`default_nettype wire

// File: design/aldet_merge.sv
// Merge stage: adds the lane squares, compares against the scaled threshold
// and runs the persistence counter. Depends on aldet_pkg.
`default_nettype none

module aldet_merge #(
	parameter int WINDOW = 16,
	localparam int SQ_W  = 2 * (aldet_pkg::SAMPLE_BITS + $clog2(WINDOW))
) (
	input  wire logic                                   clk,
	input  wire logic                                   arst_n,
	input  wire aldet_pkg::ctrl_t                       ctrl_s2,
	input  wire logic [SQ_W-1:0]                        sq_x_s2,
	input  wire logic [SQ_W-1:0]                        sq_y_s2,
	input  wire logic [SQ_W-1:0]                        sq_z_s2,
	input  wire logic [aldet_pkg::CFG_THR_BITS-1:0]     thr_cfg,
	input  wire logic [aldet_pkg::CFG_HOLD_BITS-1:0]    hold_cfg,
	output logic                                        push,
	output aldet_pkg::out_item_t                        push_item
);
	import aldet_pkg::*;

	localparam int MAG_W = SQ_W + 2;
	localparam int WW    = WINDOW * WINDOW;
	localparam int WW_W  = $clog2(WW + 1);
	localparam int THR_W = CFG_THR_BITS + WW_W;
	localparam int CMP_W = (MAG_W > THR_W) ? MAG_W : THR_W;

	logic [THR_W-1:0]         thr_q;
	logic [MAG_W-1:0]         mag_s3;
	ctrl_t                    ctrl_s3;
	logic [CFG_HOLD_BITS-1:0] run_q;
	logic [CFG_HOLD_BITS-1:0] run_d;
	logic [CFG_HOLD_BITS-1:0] hold_eff;
	logic                     over;

	// Threshold*window^2; user must do config changes only while idle; unchecked.
	always_ff @(posedge clk) begin
		thr_q <= THR_W'(thr_cfg) * THR_W'(WW);
	end

	// Sum of the three squares.
	always_ff @(posedge clk) begin
		mag_s3 <= MAG_W'(sq_x_s2) + MAG_W'(sq_y_s2) + MAG_W'(sq_z_s2);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_s3 <= '0;
		end else begin
			ctrl_s3 <= ctrl_s2;
		end
	end

	// A hold count of zero acts as one.
	assign hold_eff = (hold_cfg == '0) ? CFG_HOLD_BITS'(1) : hold_cfg;
	assign over     = CMP_W'(mag_s3) > CMP_W'(thr_q);

	// Persistence counter update for the item in the last stage.
	always_comb begin
		run_d = run_q;
		if (!ctrl_s3.ok) begin
			run_d = '0;
		end else if (ctrl_s3.full) begin
			if (!over) begin
				run_d = '0;
			end else if (run_q < hold_eff) begin
				run_d = run_q + 1'b1;
			end else begin
				run_d = hold_eff;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= '0;
		end else if (ctrl_s3.valid) begin
			run_q <= run_d;
		end
	end

	// Result item for the output queue.
	assign push                  = ctrl_s3.valid;
	assign push_item.liftoff     = ctrl_s3.ok && ctrl_s3.full && (run_d >= hold_eff);
	assign push_item.window_full = ctrl_s3.full;

endmodule

`default_nettype wire

// File: design/aldet_ofifo.sv
// Output queue of result items with an occupancy count that sets input stall.
// Depends on aldet_pkg.
`default_nettype none

module aldet_ofifo (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 reserve,
	input  wire logic                 push,
	input  wire aldet_pkg::out_item_t push_item,
	input  wire logic                 pop,
	output logic                      stall,
	output logic                      valid,
	output aldet_pkg::out_item_t      item
);
	import aldet_pkg::*;

	out_item_t             mem_q [OFIFO_DEPTH];
	logic [OFIFO_AW-1:0]   wr_q;
	logic [OFIFO_AW-1:0]   rd_q;
	logic [OFIFO_CW-1:0]   cnt_q;
	logic [OFIFO_CW-1:0]   occ_q;

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_item;
		end
	end

	// Pointers, stored count and items accepted but not yet taken.
	// The depth is a power of two, so the pointers wrap on their own.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
			occ_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= rd_q + 1'b1;
			end
			cnt_q <= cnt_q + OFIFO_CW'(push) - OFIFO_CW'(pop);
			occ_q <= occ_q + OFIFO_CW'(reserve) - OFIFO_CW'(pop);
		end
	end

	assign stall = (occ_q == OFIFO_CW'(OFIFO_DEPTH));
	assign valid = (cnt_q != '0);
	assign item  = mem_q[rd_q];

endmodule

`default_nettype wire

// File: design/accel_liftoff_detector.sv
// Channel    Direction  Signals
// sample     in         sample_valid, sample_stall, sample (x, y, z, sample_ok)
// result     out        result_valid, result_stall, result (liftoff, window_full)
// config     in/out     psel, penable, pwrite, paddr, pwdata, prdata, pready
//
// One item is taken every cycle while sample_stall is low; results pass the lane and merge registers.
// The running sums update once per item with sample_ok set; the persistence counter once per item.
// An eight-entry output queue absorbs result stalls; sample_stall rises once
// eight items are accepted but not yet taken. No clearing pass after reset:
// ring entries read as zero until the window has filled once.
// Top level of the liftoff detector; uses aldet_pkg, aldet_lane, aldet_merge,
// aldet_ofifo and accel_liftoff_detector_assert.svh.
`default_nettype none

module accel_liftoff_detector #(
	parameter int WINDOW = 16
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 sample_valid,
	output logic                                      sample_stall,
	input  wire aldet_pkg::in_item_t                  sample,
	output logic                                      result_valid,
	input  wire logic                                 result_stall,
	output aldet_pkg::out_item_t                      result,
	input  wire logic                                 psel,
	input  wire logic                                 penable,
	input  wire logic                                 pwrite,
	input  wire logic [aldet_pkg::REG_ADDR_BITS-1:0]  paddr,
	input  wire logic [31:0]                          pwdata,
	output logic [31:0]                               prdata,
	output logic                                      pready
);
	import aldet_pkg::*;

	`include "accel_liftoff_detector_assert.svh"

	localparam int AW    = $clog2(WINDOW);
	localparam int FW    = $clog2(WINDOW + 1);
	localparam int SQ_W  = 2 * (SAMPLE_BITS + $clog2(WINDOW));

	logic [CFG_THR_BITS-1:0]  thr_q;
	logic [CFG_HOLD_BITS-1:0] hold_q;
	logic                     reg_idx;
	logic                     accept;
	logic                     wr;
	logic                     pop;
	logic [AW-1:0]            wp_q;
	logic [AW-1:0]            wp_d;
	logic [FW-1:0]            fill_q;
	logic [FW-1:0]            fill_d;
	logic                     full_now;
	ctrl_t                    ctrl_s1;
	ctrl_t                    ctrl_s2;
	logic [SQ_W-1:0]          sq_x_s2;
	logic [SQ_W-1:0]          sq_y_s2;
	logic [SQ_W-1:0]          sq_z_s2;
	logic                     push;
	out_item_t                push_item;

	// Configuration registers.
	assign pready  = 1'b1;
	assign reg_idx = paddr[2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q  <= THR_RESET;
			hold_q <= HOLD_RESET;
		end else if (psel && penable && pwrite && pready) begin
			unique case (reg_idx)
				REG_THRESH: thr_q  <= pwdata;
				REG_HOLD:   hold_q <= pwdata[CFG_HOLD_BITS-1:0];
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_THRESH: prdata = thr_q;
			REG_HOLD:   prdata = 32'(hold_q);
		endcase
	end

	// Ring position and fill level, shared by all lanes.
	assign accept   = sample_valid && !sample_stall;
	assign wr       = accept && sample.sample_ok;
	assign full_now = (fill_q == FW'(WINDOW));

	always_comb begin
		wp_d   = wp_q;
		fill_d = fill_q;
		if (wr) begin
			wp_d = (wp_q == AW'(WINDOW - 1)) ? '0 : wp_q + 1'b1;
			if (!full_now) begin
				fill_d = fill_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q    <= '0;
			fill_q  <= '0;
			ctrl_s1 <= '0;
			ctrl_s2 <= '0;
		end else begin
			wp_q          <= wp_d;
			fill_q        <= fill_d;
			ctrl_s1.valid <= accept;
			ctrl_s1.ok    <= sample.sample_ok;
			ctrl_s1.full  <= (fill_d == FW'(WINDOW));
			ctrl_s2       <= ctrl_s1;
		end
	end

	// One lane per axis.
	aldet_lane #(.WINDOW(WINDOW)) u_lane_x (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (wr),
		.sample  (sample.accel_x),
		.wr_addr (wp_q),
		.rd_addr (wp_d),
		.old_ok  (full_now),
		.sq_s2   (sq_x_s2)
	);

	aldet_lane #(.WINDOW(WINDOW)) u_lane_y (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (wr),
		.sample  (sample.accel_y),
		.wr_addr (wp_q),
		.rd_addr (wp_d),
		.old_ok  (full_now),
		.sq_s2   (sq_y_s2)
	);

	aldet_lane #(.WINDOW(WINDOW)) u_lane_z (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (wr),
		.sample  (sample.accel_z),
		.wr_addr (wp_q),
		.rd_addr (wp_d),
		.old_ok  (full_now),
		.sq_s2   (sq_z_s2)
	);

	// Magnitude test and persistence.
	aldet_merge #(.WINDOW(WINDOW)) u_merge (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctrl_s2   (ctrl_s2),
		.sq_x_s2   (sq_x_s2),
		.sq_y_s2   (sq_y_s2),
		.sq_z_s2   (sq_z_s2),
		.thr_cfg   (thr_q),
		.hold_cfg  (hold_q),
		.push      (push),
		.push_item (push_item)
	);

	// Output queue.
	assign pop = result_valid && !result_stall;

	aldet_ofifo u_ofifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.reserve   (accept),
		.push      (push),
		.push_item (push_item),
		.pop       (pop),
		.stall     (sample_stall),
		.valid     (result_valid),
		.item      (result)
	);

	// Checks on the fill tracking and the result.
	`ALD_ASSERT_ALWAYS(a_fill_bound, fill_q <= FW'(WINDOW))
	`ALD_ASSERT_IMPLY(a_wp_tracks_fill, !full_now, FW'(wp_q) == fill_q)
	`ALD_ASSERT_IMPLY(a_lift_needs_full, result_valid && result.liftoff, result.window_full)

endmodule

`default_nettype wire

// File: test/tb_top.sv
// Self-checking testbench for the accelerometer liftoff detector.
// Drives sample items and APB register writes, predicts every result item in place;
// depends on aldet_pkg and the accel_liftoff_detector top level only.
`timescale 1ns / 100ps

module tb_top;
	import aldet_pkg::*;

	localparam int WINDOW          = 16;
	localparam int IDLE_LIMIT      = 2000;
	localparam int HOLD_OFF_CYCLES = 160;
	localparam int PHASES          = 10;
	localparam int PHASE_ITEMS     = 70;
	localparam int DRAIN_CYCLES    = 16;
	localparam int REPORT_LIMIT    = 10;

	localparam logic [REG_ADDR_BITS-1:0] ADDR_THRESH = {REG_THRESH, 2'b00};
	localparam logic [REG_ADDR_BITS-1:0] ADDR_HOLD   = {REG_HOLD, 2'b00};
	localparam logic [CFG_THR_BITS-1:0]  THR_MAX     = 32'd3221225472;

	localparam logic [SAMPLE_BITS-1:0] S_MAX = 16'h7FFF;
	localparam logic [SAMPLE_BITS-1:0] S_MIN = 16'h8000;

	localparam out_item_t FLAGS_EMPTY = 2'b00;
	localparam out_item_t FLAGS_FULL  = 2'b01;

	// One row of the directed table: optional register setting, then an item repeated.
	typedef struct {
		logic                     wr;
		logic [CFG_THR_BITS-1:0]  thr;
		logic [CFG_HOLD_BITS-1:0] hold;
		in_item_t                 item;
		int                       reps;
		logic                     known;
		out_item_t                want;
	} drow_t;

	logic                     clk;
	logic                     arst_n;
	logic                     sample_valid;
	logic                     sample_stall;
	in_item_t                 sample;
	logic                     result_valid;
	logic                     result_stall;
	out_item_t                result;
	logic                     psel;
	logic                     penable;
	logic                     pwrite;
	logic [REG_ADDR_BITS-1:0] paddr;
	logic [31:0]              pwdata;
	logic [31:0]              prdata;
	logic                     pready;

	// Predictor state: ring history, running sums, fill and persistence.
	logic signed [SAMPLE_BITS-1:0] hist_x [WINDOW];
	logic signed [SAMPLE_BITS-1:0] hist_y [WINDOW];
	logic signed [SAMPLE_BITS-1:0] hist_z [WINDOW];
	logic signed [19:0]            tot_x, tot_y, tot_z;
	int                            slot, depth, streak;
	logic [CFG_THR_BITS-1:0]       cur_thr;
	logic [CFG_HOLD_BITS-1:0]      cur_hold;

	out_item_t pending_results[$];
	drow_t     plan[$];

	int fails;
	int results_seen;
	int idle_cycles;
	bit calm;
	bit burst;
	bit hold_off_req;
	int mean_x, mean_y, mean_z, spread;

	accel_liftoff_detector #(.WINDOW(WINDOW)) dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample_valid),
		.sample_stall (sample_stall),
		.sample       (sample),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Advances the predictor by one item and returns the flags it should produce.
	function automatic out_item_t predict_liftoff(input in_item_t s);
		logic signed [19:0] dx, dy, dz;
		logic signed [63:0] wx, wy, wz;
		logic [63:0]        mag, lim;
		int                 need;
		out_item_t          o;
		need = (cur_hold == '0) ? 1 : int'(cur_hold);
		o.liftoff = 1'b0;
		if (!s.sample_ok) begin
			streak = 0;
		end else begin
			dx = $signed(s.accel_x);
			dy = $signed(s.accel_y);
			dz = $signed(s.accel_z);
			tot_x = tot_x + dx - hist_x[slot];
			tot_y = tot_y + dy - hist_y[slot];
			tot_z = tot_z + dz - hist_z[slot];
			hist_x[slot] = s.accel_x;
			hist_y[slot] = s.accel_y;
			hist_z[slot] = s.accel_z;
			slot = (slot == WINDOW - 1) ? 0 : slot + 1;
			if (depth < WINDOW)
				depth++;
			if (depth == WINDOW) begin
				// Exact test of the mean magnitude, scaled by the window squared.
				wx = tot_x;
				wy = tot_y;
				wz = tot_z;
				mag = wx * wx + wy * wy + wz * wz;
				lim = cur_thr;
				lim = lim * WINDOW * WINDOW;
				if (mag > lim)
					streak = (streak < need) ? streak + 1 : need;
				else
					streak = 0;
				o.liftoff = (streak >= need);
			end
		end
		o.window_full = (depth == WINDOW);
		return o;
	endfunction

	function automatic in_item_t make_sample(input logic [SAMPLE_BITS-1:0] x, y, z,
			input logic ok);
		in_item_t s;
		s.accel_x   = x;
		s.accel_y   = y;
		s.accel_z   = z;
		s.sample_ok = ok;
		return s;
	endfunction

	// One axis value scattered around a mean, clamped to the sample range.
	function automatic logic [SAMPLE_BITS-1:0] near_axis(input int m, input int sp);
		int n, v;
		n = $urandom_range(0, 2 * sp);
		v = m + n - sp;
		if (v > 32767)
			v = 32767;
		if (v < -32768)
			v = -32768;
		return v[SAMPLE_BITS-1:0];
	endfunction

	// Mostly samples around the phase's mean vector, with raw noise and dropouts.
	function automatic in_item_t random_sample();
		in_item_t s;
		int       r;
		r = $urandom_range(0, 99);
		s.accel_x   = SAMPLE_BITS'($urandom);
		s.accel_y   = SAMPLE_BITS'($urandom);
		s.accel_z   = SAMPLE_BITS'($urandom);
		s.sample_ok = 1'b1;
		if (r < 5) begin
			s.sample_ok = 1'b0;
		end else if (r >= 15) begin
			s.accel_x = near_axis(mean_x, spread);
			s.accel_y = near_axis(mean_y, spread);
			s.accel_z = near_axis(mean_z, spread);
		end
		return s;
	endfunction

	task automatic add_row(input logic wr, input logic [CFG_THR_BITS-1:0] thr,
			input logic [CFG_HOLD_BITS-1:0] hold, input in_item_t item, input int reps,
			input logic known, input out_item_t want);
		drow_t r;
		r.wr    = wr;
		r.thr   = thr;
		r.hold  = hold;
		r.item  = item;
		r.reps  = reps;
		r.known = known;
		r.want  = want;
		plan.push_back(r);
	endtask

	// Offers one item after a random gap and records its expected flags on acceptance.
	task automatic push_sample(input in_item_t s, input logic known, input out_item_t want);
		int        gap;
		out_item_t pred;
		gap = (calm || burst) ? 0 : $urandom_range(0, 7);
		@(negedge clk);
		if (gap > 0) begin
			sample_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		sample       <= s;
		sample_valid <= 1'b1;
		do @(posedge clk); while (sample_stall);
		pred = predict_liftoff(s);
		pending_results.push_back(known ? want : pred);
	endtask

	// Stops offering items and waits until every expected result has come back.
	task automatic settle_results();
		@(negedge clk);
		sample_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(negedge clk);
	endtask

	// APB write: setup cycle, access cycle, then release the bus.
	task automatic write_reg(input logic [REG_ADDR_BITS-1:0] addr, input logic [31:0] data);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= addr;
		pwdata  <= data;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (addr == ADDR_THRESH)
			cur_thr = data[CFG_THR_BITS-1:0];
		else
			cur_hold = data[CFG_HOLD_BITS-1:0];
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	// Result side: random stalls per item, plus one long hold-off on request.
	initial begin
		result_stall = 1'b0;
		@(negedge clk);
		forever begin
			int gap;
			gap = calm ? 0 : $urandom_range(0, 7);
			if (hold_off_req) begin
				hold_off_req = 1'b0;
				gap = HOLD_OFF_CYCLES;
			end
			if (gap > 0) begin
				result_stall <= 1'b1;
				repeat (gap) @(negedge clk);
				result_stall <= 1'b0;
			end
			do @(posedge clk); while (!(result_valid && !result_stall));
			@(negedge clk);
		end
	end

	// Compares each accepted result with the oldest expectation.
	always @(posedge clk) begin
		out_item_t want;
		if (arst_n && result_valid && !result_stall) begin
			results_seen++;
			if (pending_results.size() == 0) begin
				fails++;
				if (fails <= REPORT_LIMIT)
					$display("ERROR: result %0d with nothing expected: liftoff %b window_full %b",
						results_seen, result.liftoff, result.window_full);
			end else begin
				want = pending_results.pop_front();
				if (result.liftoff !== want.liftoff || result.window_full !== want.window_full) begin
					fails++;
					if (fails <= REPORT_LIMIT)
						$display("ERROR: result %0d: liftoff exp %b got %b, window_full exp %b got %b",
							results_seen, want.liftoff, result.liftoff,
							want.window_full, result.window_full);
				end
			end
		end
	end

	// Watchdog on cycles in which neither channel nor the register port moves.
	always @(posedge clk) begin
		if ((sample_valid && !sample_stall) || (result_valid && !result_stall) || psel) begin
			idle_cycles <= 0;
		end else if (idle_cycles == IDLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		longint                   mag2, thr_l;
		logic [CFG_THR_BITS-1:0]  thr_w;
		logic [CFG_HOLD_BITS-1:0] hold_w;
		logic [31:0]              hold_word;

		arst_n       = 1'b0;
		sample_valid = 1'b0;
		sample       = '0;
		psel         = 1'b0;
		penable      = 1'b0;
		pwrite       = 1'b0;
		paddr        = '0;
		pwdata       = '0;
		fails        = 0;
		results_seen = 0;
		idle_cycles  = 0;
		calm         = 1'b0;
		burst        = 1'b0;
		hold_off_req = 1'b0;
		for (int k = 0; k < WINDOW; k++) begin
			hist_x[k] = '0;
			hist_y[k] = '0;
			hist_z[k] = '0;
		end
		tot_x    = '0;
		tot_y    = '0;
		tot_z    = '0;
		slot     = 0;
		depth    = 0;
		streak   = 0;
		cur_thr  = THR_RESET;
		cur_hold = HOLD_RESET;

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed table. Reset settings first: a dropout and two extreme samples.
		add_row(1'b0, '0, '0, make_sample(S_MAX, S_MAX, S_MAX, 1'b0), 1, 1'b1, FLAGS_EMPTY);
		add_row(1'b0, '0, '0, make_sample(S_MAX, S_MAX, S_MAX, 1'b1), 1, 1'b1, FLAGS_EMPTY);
		add_row(1'b0, '0, '0, make_sample(S_MIN, S_MIN, S_MIN, 1'b1), 1, 1'b1, FLAGS_EMPTY);
		// Zero threshold, hold of one: the window is still filling.
		add_row(1'b1, '0, 8'd1, make_sample(S_MIN, S_MIN, S_MIN, 1'b1), 13, 1'b1, FLAGS_EMPTY);
		// The window fills here.
		add_row(1'b0, '0, '0, make_sample(S_MIN, S_MIN, S_MIN, 1'b1), 1, 1'b0, FLAGS_EMPTY);
		// A dropout once full clears the counter only.
		add_row(1'b0, '0, '0, make_sample(S_MAX, S_MIN, S_MAX, 1'b0), 1, 1'b1, FLAGS_FULL);
		// Largest threshold: a window of all minimum samples lands exactly on it.
		add_row(1'b1, THR_MAX, 8'd255, make_sample(S_MIN, S_MIN, S_MIN, 1'b1), 1, 1'b0,
			FLAGS_EMPTY);
		add_row(1'b1, THR_MAX - 1, 8'd255, make_sample(S_MIN, S_MIN, S_MIN, 1'b1), 1, 1'b0,
			FLAGS_EMPTY);
		// Persistence: reach a hold of three, then lower the hold below the counter.
		add_row(1'b1, '0, 8'd3, make_sample(S_MIN, S_MIN, S_MIN, 1'b1), 4, 1'b0, FLAGS_EMPTY);
		add_row(1'b1, '0, 8'd2, make_sample(S_MAX, S_MIN, 16'h0000, 1'b1), 1, 1'b0,
			FLAGS_EMPTY);
		// A hold of zero acts as a hold of one.
		add_row(1'b1, '0, 8'd0, make_sample(16'h0000, 16'h0000, 16'h0000, 1'b1), 1, 1'b0,
			FLAGS_EMPTY);
		add_row(1'b0, '0, '0, make_sample(16'h0000, 16'h0000, 16'h0000, 1'b0), 1, 1'b1,
			FLAGS_FULL);

		foreach (plan[r]) begin
			if (plan[r].wr) begin
				settle_results();
				write_reg(ADDR_THRESH, plan[r].thr);
				write_reg(ADDR_HOLD, {24'h0, plan[r].hold});
			end
			repeat (plan[r].reps)
				push_sample(plan[r].item, plan[r].known, plan[r].want);
		end

		// Random phases, each with its own mean vector and register settings.
		for (int p = 0; p < PHASES; p++) begin
			settle_results();
			mean_x = $signed(near_axis(0, 32768));
			mean_y = $signed(near_axis(0, 32768));
			mean_z = $signed(near_axis(0, 32768));
			spread = $urandom_range(16, 2048);
			case (p)
				0: begin
					thr_w  = '0;
					hold_w = 8'd1;
				end
				1: begin
					mean_x = $signed(near_axis(0, 3000));
					mean_y = $signed(near_axis(0, 3000));
					mean_z = $signed(near_axis(0, 3000));
					thr_w  = THR_RESET;
					hold_w = HOLD_RESET;
				end
				8: begin
					mean_x = -32768;
					mean_y = -32768;
					mean_z = -32768;
					spread = 64;
					thr_w  = THR_MAX;
					hold_w = 8'd255;
				end
				default: begin
					mag2  = longint'(mean_x) * mean_x + longint'(mean_y) * mean_y
						+ longint'(mean_z) * mean_z;
					thr_l = mag2 * $urandom_range(60, 140) / 100;
					if (thr_l > longint'(THR_MAX))
						thr_l = longint'(THR_MAX);
					thr_w  = thr_l[CFG_THR_BITS-1:0];
					hold_w = (p == 4) ? 8'd0 : 8'($urandom_range(1, 12));
				end
			endcase
			calm  = (p == 5);
			burst = (p == 6);
			// Upper bits of the hold word are not part of the register.
			hold_word = ($urandom & 32'hFFFF_FF00) | {24'h0, hold_w};
			write_reg(ADDR_THRESH, thr_w);
			write_reg(ADDR_HOLD, hold_word);
			if (burst)
				hold_off_req = 1'b1;
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				if (p == 3 && i == PHASE_ITEMS / 2)
					settle_results();
				push_sample(random_sample(), 1'b0, FLAGS_EMPTY);
			end
		end
		calm  = 1'b0;
		burst = 1'b0;

		settle_results();
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (fails == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
